>>> rtl/ldwt_pkg.sv
// Shared types, constants and lifting arithmetic for the 5/3 line transform.
`default_nettype none
package ldwt_pkg;

   localparam int CHAN_W      = 9;
   localparam int NUM_CHAN    = 3;
   localparam int SAMPLE_W    = CHAN_W * NUM_CHAN;   // compact sample, 27 bits
   localparam int WORD_W      = 29;                  // packed pixel word
   localparam int QUEUE_DEPTH = 4;

   // Positions in the per-command result mask, also the emit order.
   localparam int RES_UPD = 0;
   localparam int RES_D   = 1;
   localparam int RES_X   = 2;
   localparam int NUM_RES = 3;

   localparam logic signed [10:0] CLAMP_MAX = 11'sd255;

   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_SECOND = 2'd1,
      PH_EVEN   = 2'd2,
      PH_ODD    = 2'd3
   } phase_type;

   // One queued command: up to three results from one accepted sample.
   typedef struct packed {
      logic                has_upd;
      logic                has_d;
      logic                has_x;
      logic                x_last;
      logic [SAMPLE_W-1:0] upd_s;
      logic [SAMPLE_W-1:0] upd_l;
      logic [SAMPLE_W-1:0] upd_r;
      logic [SAMPLE_W-1:0] d_word;
      logic [SAMPLE_W-1:0] x_word;
   } cmd_type;

   typedef struct packed {
      logic [NUM_CHAN-1:0] flags;
      logic [SAMPLE_W-1:0] word;
   } upd_result_type;

   function automatic logic [SAMPLE_W-1:0] compact(input logic [WORD_W-1:0] p);
      return {p[28:20], p[18:10], p[8:0]};
   endfunction

   function automatic logic [WORD_W-1:0] expand(input logic [SAMPLE_W-1:0] w);
      return {w[26:18], 1'b0, w[17:9], 1'b0, w[8:0]};
   endfunction

   // Detail: s - floor((l + r) / 2), wrapped to 9 bits per channel.
   function automatic logic [SAMPLE_W-1:0] predict(input logic [SAMPLE_W-1:0] s,
                                                   input logic [SAMPLE_W-1:0] l,
                                                   input logic [SAMPLE_W-1:0] r);
      logic [SAMPLE_W-1:0] res;
      logic [CHAN_W-1:0]   sc, lc, rc;
      logic signed [9:0]   sum, half, d;
      res = '0;
      for (int c = 0; c < NUM_CHAN; c++) begin
         sc   = s[c*CHAN_W +: CHAN_W];
         lc   = l[c*CHAN_W +: CHAN_W];
         rc   = r[c*CHAN_W +: CHAN_W];
         sum  = $signed({lc[8], lc}) + $signed({rc[8], rc});
         half = sum >>> 1;
         d    = $signed({sc[8], sc}) - half;
         res[c*CHAN_W +: CHAN_W] = d[CHAN_W-1:0];
      end
      return res;
   endfunction

   // Smooth: s + floor((l + r + 2) / 4), clamped above at 255, wrapped.
   function automatic upd_result_type update(input logic [SAMPLE_W-1:0] s,
                                             input logic [SAMPLE_W-1:0] l,
                                             input logic [SAMPLE_W-1:0] r);
      upd_result_type    res;
      logic [CHAN_W-1:0] sc, lc, rc;
      logic signed [10:0] sum, q, v;
      res = '0;
      for (int c = 0; c < NUM_CHAN; c++) begin
         sc  = s[c*CHAN_W +: CHAN_W];
         lc  = l[c*CHAN_W +: CHAN_W];
         rc  = r[c*CHAN_W +: CHAN_W];
         sum = $signed({{2{lc[8]}}, lc}) + $signed({{2{rc[8]}}, rc}) + 11'sd2;
         q   = sum >>> 2;
         v   = $signed({{2{sc[8]}}, sc}) + q;
         if (v > CLAMP_MAX) begin
            v = CLAMP_MAX;
            res.flags[c] = 1'b1;
         end
         res.word[c*CHAN_W +: CHAN_W] = v[CHAN_W-1:0];
      end
      return res;
   endfunction

endpackage
`default_nettype wire

>>> rtl/ldwt_front.sv
// Front end: line phase tracking, prediction and command building.
`default_nettype none
module ldwt_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   output      logic                              in_ready,
   input  wire logic [ldwt_pkg::WORD_W-1:0]       in_word,
   input  wire logic                              in_last,
   input  wire logic                              queue_full,
   output      logic                              push,
   output      ldwt_pkg::cmd_type                 push_cmd
);

   ldwt_pkg::phase_type               phase_ff, phase_in;
   logic [ldwt_pkg::SAMPLE_W-1:0]     held_ff, held_in;
   logic [ldwt_pkg::SAMPLE_W-1:0]     pending_ff, pending_in;
   logic [ldwt_pkg::SAMPLE_W-1:0]     prev_ff, prev_in;
   logic [ldwt_pkg::SAMPLE_W-1:0]     x, d;
   logic                              accept;
   ldwt_pkg::cmd_type                 cmd;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign x        = ldwt_pkg::compact(in_word);
   assign d        = ldwt_pkg::predict(held_ff, pending_ff, x);

   always_comb begin
      phase_in   = phase_ff;
      held_in    = held_ff;
      pending_in = pending_ff;
      prev_in    = prev_ff;
      cmd        = '0;
      cmd.x_word = x;
      cmd.x_last = in_last;
      cmd.d_word = d;
      case (phase_ff)
         ldwt_pkg::PH_FIRST: begin
            cmd.has_x = 1'b1;
            prev_in   = x;
            phase_in  = ldwt_pkg::PH_SECOND;
         end
         ldwt_pkg::PH_SECOND: begin
            cmd.has_x = in_last;
            if (!in_last) pending_in = x;
            phase_in  = ldwt_pkg::PH_EVEN;
         end
         ldwt_pkg::PH_EVEN: begin
            // even final sample: raw value is the right neighbour
            cmd.has_upd = in_last;
            cmd.has_x   = in_last;
            cmd.upd_s   = pending_ff;
            cmd.upd_l   = prev_ff;
            cmd.upd_r   = x;
            if (!in_last) held_in = x;
            phase_in    = ldwt_pkg::PH_ODD;
         end
         ldwt_pkg::PH_ODD: begin
            cmd.has_upd = 1'b1;
            cmd.has_d   = 1'b1;
            cmd.has_x   = in_last;
            cmd.upd_s   = pending_ff;
            cmd.upd_l   = prev_ff;
            cmd.upd_r   = d;
            prev_in     = d;
            pending_in  = x;
            phase_in    = ldwt_pkg::PH_EVEN;
         end
         default: begin
            phase_in = ldwt_pkg::PH_FIRST;
         end
      endcase
      if (in_last) phase_in = ldwt_pkg::PH_FIRST;
   end

   assign push     = accept && (cmd.has_upd || cmd.has_d || cmd.has_x);
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= ldwt_pkg::PH_FIRST;
         held_ff    <= '0;
         pending_ff <= '0;
         prev_ff    <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         held_ff    <= held_in;
         pending_ff <= pending_in;
         prev_ff    <= prev_in;
      end
   end

   a_last_restarts_line: assert property (@(posedge clock) disable iff (reset)
      accept && in_last |=> phase_ff == ldwt_pkg::PH_FIRST)
      else $error("line end did not return to the first-sample phase");

   a_push_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_full)
      else $error("command pushed into a full queue");

endmodule
`default_nettype wire

>>> rtl/ldwt_queue.sv
// Small register FIFO of commands between front and back end.
`default_nettype none
module ldwt_queue #(
   parameter int DEPTH = ldwt_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire ldwt_pkg::cmd_type push_cmd,
   input  wire logic              pop,
   output      logic              full,
   output      logic              head_valid,
   output      ldwt_pkg::cmd_type head_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   ldwt_pkg::cmd_type entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (!push && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_cmd;
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from an empty queue");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a push");

endmodule
`default_nettype wire

>>> rtl/ldwt_back.sv
// Back end: update step and serial emission of each command's results.
`default_nettype none
module ldwt_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          head_valid,
   input  wire ldwt_pkg::cmd_type             head_cmd,
   output      logic                          pop,
   output      logic                          out_valid,
   input  wire logic                          out_ready,
   output      logic [ldwt_pkg::WORD_W-1:0]   out_word,
   output      logic [ldwt_pkg::NUM_CHAN-1:0] out_flags,
   output      logic                          out_last
);

   logic [ldwt_pkg::NUM_RES-1:0]   done_mask_ff, done_mask_in;
   logic [ldwt_pkg::NUM_RES-1:0]   mask, remain, sel, rest;
   logic                           out_free, load;
   ldwt_pkg::upd_result_type       upd;

   logic                           out_valid_ff, out_valid_in;
   logic [ldwt_pkg::WORD_W-1:0]    out_word_ff, out_word_in;
   logic [ldwt_pkg::NUM_CHAN-1:0]  out_flags_ff, out_flags_in;
   logic                           out_last_ff, out_last_in;

   assign upd = ldwt_pkg::update(head_cmd.upd_s, head_cmd.upd_l, head_cmd.upd_r);

   always_comb begin
      mask                    = '0;
      mask[ldwt_pkg::RES_UPD] = head_cmd.has_upd;
      mask[ldwt_pkg::RES_D]   = head_cmd.has_d;
      mask[ldwt_pkg::RES_X]   = head_cmd.has_x;
      remain = mask & ~done_mask_ff;
      // lowest pending result goes first: update, detail, pass-through
      sel = remain & (~remain + 1'b1);
      rest = remain & ~sel;

      out_free = !out_valid_ff || out_ready;
      load     = head_valid && out_free;
      pop      = load && (rest == '0);

      done_mask_in = done_mask_ff;
      if (load) done_mask_in = pop ? '0 : (done_mask_ff | sel);

      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      out_flags_in = out_flags_ff;
      out_last_in  = out_last_ff;
      if (out_free) out_valid_in = load;
      if (load) begin
         out_flags_in = '0;
         out_last_in  = 1'b0;
         if (sel[ldwt_pkg::RES_UPD]) begin
            out_word_in  = ldwt_pkg::expand(upd.word);
            out_flags_in = upd.flags;
         end else if (sel[ldwt_pkg::RES_D]) begin
            out_word_in  = ldwt_pkg::expand(head_cmd.d_word);
         end else begin
            out_word_in  = ldwt_pkg::expand(head_cmd.x_word);
            out_last_in  = head_cmd.x_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_mask_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         done_mask_ff <= done_mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      out_flags_ff <= out_flags_in;
      out_last_ff  <= out_last_in;
   end

   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;
   assign out_flags = out_flags_ff;
   assign out_last  = out_last_ff;

   a_cmd_not_empty: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (head_cmd.has_upd || head_cmd.has_d || head_cmd.has_x))
      else $error("queued command carries no result");

   a_flags_only_update: assert property (@(posedge clock) disable iff (reset)
      load && !sel[ldwt_pkg::RES_UPD] |=> out_flags_ff == '0)
      else $error("clamp flags on a result that is not an update");

endmodule
`default_nettype wire

>>> rtl/lifting_dwt53_rgb_line_core.sv
// Top level of the one-level 5/3 lifting transform over a line of RGB pixels.
//
//  channel   dir  transfer when           payload
//  req_*     in   req_tvalid & tready   tdata[28:0] pixel word, tlast line end
//  rsp_*     out  rsp_tvalid & tready   tdata[28:0] coefficient word,
//                                        tuser[2:0] clamp flags, tlast line done
//
//  One sample accepted per cycle while the command queue has room; results
//  leave at one per cycle from the output register while rsp_tready is high, so
//  the queue absorbs the two- and three-result bursts of odd and final samples.
//  Each input transfer is registered in the command queue, then in the output register.
//  Synchronous active-high reset clears line phase, queue and output valid.
//  A stalled result side fills the queue, then drops req_tready.
`default_nettype none
module lifting_dwt53_rgb_line_core #(
   parameter int QUEUE_DEPTH = ldwt_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // slave side
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,   // [28:0] pixel_word, [31:29] zero
   input  wire logic        req_tlast,   // line_end
   // master side
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,   // [28:0] coeff_word, [31:29] zero
   output      logic [2:0]  rsp_tuser,   // [2:0] clamp_flags
   output      logic        rsp_tlast    // line_done
);

   logic                          queue_full;
   logic                          push, pop, head_valid;
   ldwt_pkg::cmd_type             push_cmd, head_cmd;
   logic [ldwt_pkg::WORD_W-1:0]   coeff;

   // Front: phase tracking and detail prediction at the input transfer.
   ldwt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_word    (req_tdata[ldwt_pkg::WORD_W-1:0]),
      .in_last    (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // Commands wait here so either side can stall alone.
   ldwt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // Back: update step and one result per cycle into the output register while it is free.
   ldwt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_word   (coeff),
      .out_flags  (rsp_tuser),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {{(32 - ldwt_pkg::WORD_W){1'b0}}, coeff};

endmodule
`default_nettype wire
